/* sv/spq_pkg.sv */
// Shared types and constants for the segment packing transmit queue.
package spq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int SEGMENT_BYTES = 2048;

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int FILL_W = 11;
    localparam int UNC_W  = 10;
    localparam int SUM_W  = 13;

    localparam logic [UNC_W-1:0] UNC_MAX   = {UNC_W{1'b1}};
    localparam logic [SUM_W-1:0] HDR_BYTES = SUM_W'(4);
    localparam logic [SUM_W-1:0] SEG_LIMIT = SUM_W'(SEGMENT_BYTES);

    // commands
    localparam logic [2:0] CMD_RESERVE = 3'd0;
    localparam logic [2:0] CMD_COMMIT  = 3'd1;
    localparam logic [2:0] CMD_FLUSH   = 3'd2;
    localparam logic [2:0] CMD_QUERY   = 3'd3;
    localparam logic [2:0] CMD_RELEASE = 3'd4;
    localparam logic [2:0] CMD_CLEAR   = 3'd5;

    // result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    // padding modes
    localparam logic [1:0] ALIGN_NONE  = 2'd0;
    localparam logic [1:0] ALIGN_2     = 2'd1;
    localparam logic [1:0] ALIGN_RESET = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [10:0] packet_bytes;
        logic [3:0]  segment_handle;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  seg_index;
        logic [10:0] payload_offset;
        logic [15:0] header_ctr;
        logic [10:0] header_dlc;
        logic [10:0] seg_bytes;
        logic [63:0] bytes_sent;
        logic        pending;
    } out_word_t;

endpackage

/* sv/segment_packing_tx_queue_top.sv */
// Segment packing transmit queue: reserve, commit, flush, head query, release and clear.
//
//  channel | direction | ports                          | word
//  --------+-----------+--------------------------------+-------------------------
//  s_      | in        | s_valid  s_ready  s_data       | cmd, packet_bytes, handle
//  m_      | out       | m_valid  m_ready  m_data       | status, indices, counters
//  cfg_    | in        | cfg_wr_en  cfg_wr_data         | align_mode
//
//  One word per cycle sustained while m_ready stays high. A word is captured in the
//  input register, then the command logic updates the queue state and loads the
//  result register, whose output drives m_valid.
//  Reset (aresetn low, synchronous) opens segment 0 and sets align_mode to 4 bytes.
//  When m_ready is low the result holds and s_ready drops once the input register
//  is also full.
module segment_packing_tx_queue_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  spq_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output spq_pkg::out_word_t  m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data
);
    import spq_pkg::*;

    // input register
    logic      in_vld_reg;
    in_word_t  in_data_reg;
    logic      advance;

    // result register
    logic      out_vld_reg;
    out_word_t out_data_reg;
    out_word_t out_next;

    // queue state
    logic [1:0]        align_reg;
    logic [IDX_W-1:0]  ri_reg, ri_next;
    logic [CNT_W-1:0]  qc_reg, qc_next;
    logic              open_reg, open_next;
    logic [15:0]       ctr_reg, ctr_next;
    logic [63:0]       total_reg, total_next;

    // segment register files, one read and one write port each
    logic [FILL_W-1:0] fill_mem [QUEUE_DEPTH];
    logic [UNC_W-1:0]  unc_mem  [QUEUE_DEPTH];
    logic              fill_we, unc_we;
    logic [IDX_W-1:0]  fill_waddr, unc_waddr, fill_raddr, unc_raddr;
    logic [FILL_W-1:0] fill_wdata, fill_rd;
    logic [UNC_W-1:0]  unc_wdata, unc_rd;

    logic [IDX_W-1:0]  cur_slot, new_slot;
    logic [11:0]       pkt_ext, dlc;
    logic [SUM_W-1:0]  msg, fill_sum;
    logic              too_large, need_open, q_full;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            align_reg <= ALIGN_RESET;
        end else if (cfg_wr_en) begin
            align_reg <= cfg_wr_data;
        end
    end

    // slot arithmetic wraps at the ring size
    assign cur_slot = ri_reg + qc_reg[IDX_W-1:0] - IDX_W'(1);
    assign new_slot = ri_reg + qc_reg[IDX_W-1:0];

    // fill is read at the current segment for reserve/flush, else at the head
    assign fill_raddr = (in_data_reg.cmd == CMD_RESERVE || in_data_reg.cmd == CMD_FLUSH)
                        ? cur_slot : ri_reg;
    always_comb begin
        case (in_data_reg.cmd)
            CMD_RESERVE: unc_raddr = cur_slot;
            CMD_COMMIT:  unc_raddr = in_data_reg.segment_handle[IDX_W-1:0];
            default:     unc_raddr = ri_reg;
        endcase
    end
    assign fill_rd = fill_mem[fill_raddr];
    assign unc_rd  = unc_mem[unc_raddr];

    // padded length and message size
    assign pkt_ext = {1'b0, in_data_reg.packet_bytes};
    always_comb begin
        case (align_reg)
            ALIGN_NONE: dlc = pkt_ext;
            ALIGN_2:    dlc = (pkt_ext + 12'd1) & ~12'd1;
            default:    dlc = (pkt_ext + 12'd3) & ~12'd3;
        endcase
    end
    assign msg       = {1'b0, dlc} + HDR_BYTES;
    assign too_large = msg >= SEG_LIMIT;
    assign fill_sum  = SUM_W'(fill_rd) + msg;
    assign need_open = !open_reg || fill_sum >= SEG_LIMIT;
    assign q_full    = qc_reg == CNT_W'(QUEUE_DEPTH);

    always_comb begin
        ri_next    = ri_reg;
        qc_next    = qc_reg;
        open_next  = open_reg;
        ctr_next   = ctr_reg;
        total_next = total_reg;
        fill_we    = 1'b0;
        fill_waddr = cur_slot;
        fill_wdata = '0;
        unc_we     = 1'b0;
        unc_waddr  = cur_slot;
        unc_wdata  = '0;
        out_next   = '0;

        case (in_data_reg.cmd)
            CMD_RESERVE: begin
                if (too_large) begin
                    out_next.status = ST_TOO_LARGE;
                end else if (need_open && q_full) begin
                    open_next       = 1'b0;
                    out_next.status = ST_FULL;
                end else begin
                    fill_we  = 1'b1;
                    unc_we   = 1'b1;
                    ctr_next = ctr_reg + 16'd1;
                    out_next.header_ctr = ctr_reg;
                    out_next.header_dlc = dlc[10:0];
                    if (need_open) begin
                        // first packet of a fresh segment
                        open_next  = 1'b1;
                        qc_next    = qc_reg + CNT_W'(1);
                        fill_waddr = new_slot;
                        fill_wdata = msg[FILL_W-1:0];
                        unc_waddr  = new_slot;
                        unc_wdata  = UNC_W'(1);
                        out_next.seg_index      = 4'(new_slot);
                        out_next.payload_offset = 11'(HDR_BYTES);
                    end else begin
                        fill_wdata = fill_sum[FILL_W-1:0];
                        unc_wdata  = (unc_rd == UNC_MAX) ? unc_rd : unc_rd + UNC_W'(1);
                        out_next.seg_index      = 4'(cur_slot);
                        out_next.payload_offset = FILL_W'(SUM_W'(fill_rd) + HDR_BYTES);
                    end
                end
            end
            CMD_COMMIT: begin
                if (unc_rd != '0) begin
                    unc_we    = 1'b1;
                    unc_waddr = unc_raddr;
                    unc_wdata = unc_rd - UNC_W'(1);
                end
            end
            CMD_FLUSH: begin
                if (open_reg && fill_rd != '0) begin
                    if (q_full) begin
                        open_next       = 1'b0;
                        out_next.status = ST_FULL;
                    end else begin
                        open_next  = 1'b1;
                        qc_next    = qc_reg + CNT_W'(1);
                        fill_we    = 1'b1;
                        fill_waddr = new_slot;
                        unc_we     = 1'b1;
                        unc_waddr  = new_slot;
                    end
                end
            end
            CMD_QUERY, CMD_RELEASE: begin
                if (qc_reg > CNT_W'(1) && unc_rd == '0) begin
                    if (fill_rd == '0) begin
                        // empty head is dropped
                        ri_next = ri_reg + IDX_W'(1);
                        qc_next = qc_reg - CNT_W'(1);
                        out_next.status = ST_NOT_READY;
                    end else begin
                        out_next.seg_index = 4'(ri_reg);
                        out_next.seg_bytes = fill_rd;
                        if (in_data_reg.cmd == CMD_RELEASE) begin
                            total_next = total_reg + 64'(fill_rd);
                            ri_next    = ri_reg + IDX_W'(1);
                            qc_next    = qc_reg - CNT_W'(1);
                        end
                    end
                end else begin
                    out_next.status = ST_NOT_READY;
                end
            end
            CMD_CLEAR: begin
                ri_next    = '0;
                qc_next    = CNT_W'(1);
                open_next  = 1'b1;
                total_next = '0;
                fill_we    = 1'b1;
                fill_waddr = '0;
                unc_we     = 1'b1;
                unc_waddr  = '0;
            end
            default: begin
            end
        endcase

        out_next.bytes_sent = total_next;
        out_next.pending    = qc_next > CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ri_reg    <= '0;
            qc_reg    <= CNT_W'(1);
            open_reg  <= 1'b1;
            ctr_reg   <= '0;
            total_reg <= '0;
        end else if (advance) begin
            ri_reg    <= ri_next;
            qc_reg    <= qc_next;
            open_reg  <= open_next;
            ctr_reg   <= ctr_next;
            total_reg <= total_next;
        end
    end

    // only segment 0 has a defined value after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_mem[0] <= '0;
            unc_mem[0]  <= '0;
        end else if (advance) begin
            if (fill_we) begin
                fill_mem[fill_waddr] <= fill_wdata;
            end
            if (unc_we) begin
                unc_mem[unc_waddr] <= unc_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_next;
        end
    end

`ifndef SYNTH
    a_qc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        qc_reg >= CNT_W'(1) && qc_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && out_vld_reg && !m_ready) |-> !s_ready)
        else $error("input taken while both stages are stalled");

    a_total_only_on_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_data_reg.cmd != CMD_RELEASE && in_data_reg.cmd != CMD_CLEAR)
        |=> $stable(total_reg))
        else $error("byte total changed outside release or clear");

    a_ctr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_data_reg.cmd != CMD_RESERVE) |=> $stable(ctr_reg))
        else $error("message counter moved without a reserve");
`endif

endmodule

/* dv/segment_queue_checker.sv */
// Checker for the segment packing queue: predicts each result word and compares it.
module segment_queue_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  spq_pkg::in_word_t   s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  spq_pkg::out_word_t  m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data,
    output int                  fail_count,
    output int                  expected_left
);
    timeunit 1ns;
    timeprecision 1ps;
    import spq_pkg::*;

    localparam int MAX_PRINTED = 100;

    // predicted queue state
    logic [IDX_W-1:0]  head_idx;
    logic [CNT_W-1:0]  seg_count;
    bit                cur_open;
    logic [FILL_W-1:0] fill_bytes [QUEUE_DEPTH];
    logic [UNC_W-1:0]  writers    [QUEUE_DEPTH];
    logic [15:0]       msg_ctr;
    logic [63:0]       sent_total;
    logic [1:0]        align;

    out_word_t expected_results[$];
    int        errors = 0;
    int        results_seen = 0;

    assign fail_count = errors;

    function automatic logic [IDX_W-1:0] cur_slot();
        return IDX_W'((int'(head_idx) + int'(seg_count) - 1) % QUEUE_DEPTH);
    endfunction

    function automatic void open_next();
        int slot;
        if (seg_count >= QUEUE_DEPTH) begin
            cur_open = 1'b0;
        end else begin
            slot = (int'(head_idx) + int'(seg_count)) % QUEUE_DEPTH;
            fill_bytes[slot] = '0;
            writers[slot]    = '0;
            cur_open         = 1'b1;
            seg_count        = seg_count + 1'b1;
        end
    endfunction

    function automatic void drop_head();
        head_idx  = IDX_W'((int'(head_idx) + 1) % QUEUE_DEPTH);
        seg_count = seg_count - 1'b1;
    endfunction

    function automatic void restart_queue();
        head_idx   = '0;
        seg_count  = '0;
        cur_open   = 1'b0;
        sent_total = '0;
        open_next();
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            fill_bytes[i] = '0;
            writers[i]    = '0;
        end
        msg_ctr = '0;
        align   = ALIGN_RESET;
        restart_queue();
    endfunction

    // Applies one command word to the predicted state and returns its result word.
    function automatic out_word_t run_queue_command(in_word_t w);
        out_word_t        r;
        int               dlc;
        int               msg;
        logic [IDX_W-1:0] slot;
        r = '0;
        case (w.cmd)
            CMD_RESERVE: begin
                dlc = int'(w.packet_bytes);
                if (align == ALIGN_2)
                    dlc = (dlc + 1) & 'hFFFE;
                else if (align >= ALIGN_RESET)
                    dlc = (dlc + 3) & 'hFFFC;   // mode 3 pads like mode 2
                msg = dlc + 4;
                if (msg >= SEGMENT_BYTES) begin
                    r.status = ST_TOO_LARGE;
                end else begin
                    if (!cur_open || int'(fill_bytes[cur_slot()]) + msg >= SEGMENT_BYTES)
                        open_next();
                    if (cur_open) begin
                        slot             = cur_slot();
                        r.seg_index      = slot;
                        r.payload_offset = 11'(int'(fill_bytes[slot]) + 4);
                        r.header_ctr     = msg_ctr;
                        r.header_dlc     = 11'(dlc);
                        msg_ctr          = msg_ctr + 1'b1;
                        fill_bytes[slot] = FILL_W'(int'(fill_bytes[slot]) + msg);
                        if (writers[slot] != UNC_MAX)
                            writers[slot] = writers[slot] + 1'b1;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
            end
            CMD_COMMIT: begin
                if (writers[w.segment_handle] != '0)
                    writers[w.segment_handle] = writers[w.segment_handle] - 1'b1;
            end
            CMD_FLUSH: begin
                if (cur_open && fill_bytes[cur_slot()] != '0) begin
                    open_next();
                    if (!cur_open)
                        r.status = ST_FULL;
                end
            end
            CMD_QUERY, CMD_RELEASE: begin
                if (seg_count > 1 && writers[head_idx] == '0) begin
                    if (fill_bytes[head_idx] == '0) begin
                        drop_head();    // empty head is skipped, not counted
                        r.status = ST_NOT_READY;
                    end else begin
                        r.seg_index = head_idx;
                        r.seg_bytes = fill_bytes[head_idx];
                        if (w.cmd == CMD_RELEASE) begin
                            sent_total = sent_total + 64'(fill_bytes[head_idx]);
                            drop_head();
                        end
                    end
                end else begin
                    r.status = ST_NOT_READY;
                end
            end
            CMD_CLEAR: restart_queue();
            default: ;
        endcase
        r.bytes_sent = sent_total;
        r.pending    = seg_count > 1;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    task automatic compare_field(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                      results_seen, field, got, want));
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            reset_model();
            expected_results.delete();
        end else begin
            if (cfg_wr_en)
                align = cfg_wr_data;
            // compare before pushing: a word's own result is never due on its accept edge
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status",         m_data.status,         want.status);
                    compare_field("seg_index",      m_data.seg_index,      want.seg_index);
                    compare_field("payload_offset", m_data.payload_offset,
                                  want.payload_offset);
                    compare_field("header_ctr",     m_data.header_ctr,     want.header_ctr);
                    compare_field("header_dlc",     m_data.header_dlc,     want.header_dlc);
                    compare_field("seg_bytes",      m_data.seg_bytes,      want.seg_bytes);
                    compare_field("bytes_sent",     m_data.bytes_sent,     want.bytes_sent);
                    compare_field("pending",        m_data.pending,        want.pending);
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(run_queue_command(s_data));
        end
        expected_left <= expected_results.size();
    end

endmodule

/* dv/tb_segment_packing_tx_queue_top.sv */
// Testbench top for the segment packing transmit queue: stimulus, flow control and verdict.
module tb_segment_packing_tx_queue_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spq_pkg::*;

    // commands the block treats as no-ops
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    // padding code 3 is outside the documented range but behaves like 4-byte padding
    localparam logic [1:0] ALIGN_4_ALIAS = 2'd3;

    // stimulus mixes
    localparam int MIX_FIXED  = 0;  // word given by the caller
    localparam int MIX_NORMAL = 1;  // full command mix, drains the ring
    localparam int MIX_FILL   = 2;  // reserves, commits, flushes and queries only: ring fills up

    localparam int IDLE_PCT        = 34;
    localparam int HOLD_OFF_CYCLES = 400;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    in_word_t   s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    out_word_t  m_data;
    logic       cfg_wr_en   = 1'b0;
    logic [1:0] cfg_wr_data = ALIGN_RESET;

    int fail_count;
    int expected_left;

    // flow control knobs shared by sender and receiver
    bit          calm      = 1'b0;  // no idling on either side while set
    int unsigned hold_left = 0;     // receiver hold-off, counted down by the receiver

    // stimulus-side bookkeeping, fed from the result channel
    logic [2:0]       issued_cmds[$];    // commands in accept order, popped per result
    logic [IDX_W-1:0] owed_commits[$];   // segments with a reservation still to commit
    logic [15:0]      safe_slots = 16'h0001;  // entries known written; entry 0 from reset
    int               status_seen[4];
    int               words_sent = 0;

    segment_packing_tx_queue_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    segment_queue_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop; a correct run needs only a few percent of this.
    initial begin
        #2_000_000;
        $display("timeout: %0d result words still outstanding", expected_left);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random back-pressure, a long hold-off on request, none while calm.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Track which reserves succeeded so commits go to real, written segments.
    always @(posedge aclk) begin
        logic [2:0] cmd;
        if (aresetn) begin
            if (m_valid && m_ready && issued_cmds.size() > 0) begin
                cmd = issued_cmds.pop_front();
                status_seen[m_data.status]++;
                if (cmd == CMD_RESERVE && m_data.status == ST_OK) begin
                    owed_commits.push_back(m_data.seg_index);
                    safe_slots[m_data.seg_index] = 1'b1;
                end
            end
            if (s_valid && s_ready)
                issued_cmds.push_back(s_data.cmd);
        end
    end

    function automatic in_word_t word_of(logic [2:0] cmd, int bytes, int handle);
        in_word_t w;
        w.cmd            = cmd;
        w.packet_bytes   = 11'(bytes);
        w.segment_handle = 4'(handle);
        return w;
    endfunction

    // One random command word. Unused fields carry random noise.
    function automatic in_word_t pick_word(bit filling);
        in_word_t         w;
        int               roll;
        int               size_roll;
        bit               noise;
        logic [IDX_W-1:0] h;
        w     = word_of(CMD_RESERVE, $urandom_range(2047), $urandom_range(15));
        noise = 1'b0;
        roll  = $urandom_range(99);
        if (filling) begin
            if (roll < 55)      w.cmd = CMD_RESERVE;
            else if (roll < 85) w.cmd = CMD_COMMIT;
            else if (roll < 97) w.cmd = CMD_FLUSH;
            else                w.cmd = CMD_QUERY;
        end else if (roll < 32) w.cmd = CMD_RESERVE;
        else if (roll < 64)     w.cmd = CMD_COMMIT;
        else if (roll < 70)     w.cmd = CMD_FLUSH;
        else if (roll < 80)     w.cmd = CMD_QUERY;
        else if (roll < 95)     w.cmd = CMD_RELEASE;
        else if (roll < 96)     w.cmd = CMD_CLEAR;
        else if (roll < 98)     w.cmd = (roll % 2) ? CMD_SPARE_7 : CMD_SPARE_6;
        else                    noise = 1'b1;   // reserve of any size, often too large

        // mostly small packets so several share a segment, a few big ones
        if (w.cmd == CMD_RESERVE && !noise) begin
            size_roll = $urandom_range(99);
            if (size_roll < 80)
                w.packet_bytes = 11'($urandom_range(120));
            else if (size_roll < 95)
                w.packet_bytes = 11'($urandom_range(1000, 121));
        end

        // commit what was reserved; now and then a written segment at random
        if (w.cmd == CMD_COMMIT) begin
            if (owed_commits.size() > 0 && $urandom_range(9) != 0) begin
                w.segment_handle = owed_commits.pop_front();
            end else begin
                do h = IDX_W'($urandom_range(QUEUE_DEPTH - 1));
                while (!safe_slots[h]);
                w.segment_handle = h;
            end
        end
        return w;
    endfunction

    // Offer one word: optional idle gap, then hold valid until the word is taken.
    // Random words are built at the driving edge so the bookkeeping is settled.
    task automatic offer(input in_word_t fixed, input int mix);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= (mix == MIX_FIXED) ? fixed : pick_word(mix == MIX_FILL);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic run_random(input int count, input int mix);
        repeat (count) offer('0, mix);
    endtask

    // Stop offering and wait until every result word has come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_left != 0) @(negedge aclk);
    endtask

    // Padding mode changes only with the pipe empty.
    task automatic write_align(input logic [1:0] mode);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        in_word_t directed[$];

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed pass at the reset padding (4 bytes). Walks segment 0 through
        // reserve, commit, query, release, plus the boundary and no-op cases.
        directed = '{
            word_of(CMD_QUERY,   0,    0),   // only the current segment: nothing ready
            word_of(CMD_RELEASE, 0,    15),  // same for release
            word_of(CMD_FLUSH,   0,    0),   // flush of an empty segment does nothing
            word_of(CMD_COMMIT,  0,    0),   // writer count already zero, stays zero
            word_of(CMD_SPARE_6, 2047, 15),  // undefined commands are no-ops
            word_of(CMD_SPARE_7, 0,    0),
            word_of(CMD_RESERVE, 0,    0),   // zero-byte packet: header only
            word_of(CMD_RESERVE, 1,    0),   // pads up to 4
            word_of(CMD_RESERVE, 2041, 0),   // pads to 2044, plus header hits the limit
            word_of(CMD_RESERVE, 2047, 0),   // largest field value, too large
            word_of(CMD_RESERVE, 2040, 0),   // largest that fits: opens segment 1
            word_of(CMD_QUERY,   0,    0),   // head still has writers
            word_of(CMD_COMMIT,  0,    0),
            word_of(CMD_COMMIT,  0,    0),
            word_of(CMD_QUERY,   0,    0),   // head complete
            word_of(CMD_RELEASE, 0,    0),   // byte count moves
            word_of(CMD_QUERY,   0,    0),   // only current left
            word_of(CMD_FLUSH,   0,    0),   // closes segment 1
            word_of(CMD_COMMIT,  0,    1),
            word_of(CMD_RELEASE, 0,    0),
            word_of(CMD_RESERVE, 3,    10),
            word_of(CMD_CLEAR,   0,    0),   // restart, counter kept, bytes zeroed
            word_of(CMD_QUERY,   0,    0)
        };
        foreach (directed[i]) offer(directed[i], MIX_FIXED);

        // No padding: exact fit and one byte over.
        write_align(ALIGN_NONE);
        offer(word_of(CMD_RESERVE, 2043, 5), MIX_FIXED);
        offer(word_of(CMD_RESERVE, 2044, 5), MIX_FIXED);
        run_random(300, MIX_NORMAL);

        // 2-byte padding. Receiver holds off long enough to back up the input,
        // while the ring is driven into overflow.
        write_align(ALIGN_2);
        @(posedge aclk);
        hold_left = HOLD_OFF_CYCLES;
        run_random(150, MIX_FILL);
        run_random(300, MIX_NORMAL);

        // Undocumented code 3, with both sides streaming at full rate.
        write_align(ALIGN_4_ALIAS);
        calm = 1'b1;
        run_random(300, MIX_NORMAL);
        calm = 1'b0;

        // Back to the reset padding for the longest stretch.
        write_align(ALIGN_RESET);
        run_random(500, MIX_NORMAL);

        drain();
        repeat (8) @(negedge aclk);

        $display("run: %0d words, padding none/2/4/code 3, %0d-cycle result stall",
                 words_sent, HOLD_OFF_CYCLES);
        $display("results: ok %0d, ring full %0d, nothing ready %0d, too large %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOT_READY],
                 status_seen[ST_TOO_LARGE]);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
